/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl file that carries concurrent checks
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hw/rtl/bspq_pkg.sv */
// types, codes and helpers for the banked strict priority queues
// no dependencies; imported by the top level
package bspq_pkg;

    localparam int LEVELS  = 3;
    localparam int ID_W    = 16;
    localparam int AGE_W   = 8;
    localparam int PRI_W   = 2;
    localparam int ENTRY_W = ID_W + AGE_W + PRI_W;

    // operation codes carried in the input tuser
    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_FIND = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    // result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_EMPTY     = 3'd2;
    localparam logic [2:0] STAT_BAD_BANK  = 3'd3;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

    // fifo levels in strict priority order
    localparam logic [1:0] LVL_CRIT   = 2'd0;
    localparam logic [1:0] LVL_URGENT = 2'd1;
    localparam logic [1:0] LVL_NORMAL = 2'd2;

    // priority values that select the two upper levels
    localparam logic [PRI_W-1:0] PRI_CRIT   = 2'd1;
    localparam logic [PRI_W-1:0] PRI_URGENT = 2'd2;

    typedef struct packed {
        logic [2:0]       status;
        logic [ID_W-1:0]  out_id;
        logic [AGE_W-1:0] out_age;
        logic [PRI_W-1:0] out_priority;
        logic [2:0]       found_bank;
        logic [1:0]       found_level;
        logic [4:0]       found_position;
    } res_t;

    // fifo level picked by a record priority
    function automatic logic [1:0] level_of(input logic [PRI_W-1:0] pri);
        logic [1:0] lvl;
        case (pri)
            PRI_CRIT:   lvl = LVL_CRIT;
            PRI_URGENT: lvl = LVL_URGENT;
            default:    lvl = LVL_NORMAL;
        endcase
        return lvl;
    endfunction

endpackage

/* hw/rtl/bspq_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies; used for the entry store and the descriptor store
module bspq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/bspq_desc_store.sv */
// per-fifo descriptor store {head, count} with per-entry valid bits
// depends on bspq_ram; entries not yet written read as zero
module bspq_desc_store #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 15
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [DEPTH-1:0] vld_reg;
    logic             rd_vld_reg;
    logic [WIDTH-1:0] ram_q;

    bspq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // valid bits: cleared by reset, set on first write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // an unwritten descriptor reads as an empty fifo at head zero
    assign rd_data = rd_vld_reg ? ram_q : '0;

endmodule

/* hw/rtl/banked_strict_priority_queues.sv */
// enqueue: descriptor read, then the entry write and the descriptor write back together
// dequeue: one descriptor read per level visited up to a non-empty one, then the head entry read
// find: one descriptor read per fifo visited and one ram read per entry compared
// invalid bank and unused mode answer without a memory access; the output register frees the input
// reset: synchronous, clears descriptor valid bits at once, no clearing pass
// entry store is not cleared; depends on bspq_pkg, bspq_ram, bspq_desc_store
`include "assert_macros.svh"

module banked_strict_priority_queues
    import bspq_pkg::*;
#(
    parameter int BANK_COUNT = 5,
    parameter int FIFO_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // bank[2:0], rec_id[18:3], rec_age[26:19],
                                   // rec_priority[28:27], zero fill[31:29]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_id[15:0], out_age[23:16], out_priority[25:24],
                                   // found_bank[28:26], found_level[30:29],
                                   // found_position[35:31], zero fill[39:36]
    output logic [2:0]  m_tuser    // status[2:0]
);

    localparam int NFIFO     = BANK_COUNT * LEVELS;
    localparam int FIFO_W    = $clog2(NFIFO);
    localparam int HEAD_W    = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int DESC_W    = HEAD_W + CNT_W;
    localparam int ENT_DEPTH = NFIFO * FIFO_DEPTH;
    localparam int ENT_AW    = $clog2(ENT_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DESC_RD  = 6'b000010,
        S_DESC_CHK = 6'b000100,
        S_ENT_RD   = 6'b001000,
        S_ENT_CHK  = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         mode_reg, mode_next;
    logic [2:0]         bank_reg, bank_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic [PRI_W-1:0]   pri_reg, pri_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    res_t               res_reg, res_next;
    res_t               m_res_reg;
    logic               m_tvalid_reg;

    logic               s_xfer;
    logic               bad_bank;
    logic               out_load;
    logic               find_adv;
    logic [FIFO_W-1:0]  fifo_idx;
    logic [HEAD_W-1:0]  desc_head;
    logic [CNT_W-1:0]   desc_cnt;
    logic [DESC_W-1:0]  desc_q;
    logic [HEAD_W-1:0]  slot_head;
    logic [CNT_W-1:0]   slot_off;
    logic [SUM_W-1:0]   slot_sum;
    logic [HEAD_W-1:0]  slot;
    logic [HEAD_W-1:0]  head_inc;
    logic [CNT_W-1:0]   pos_inc;
    logic [ENT_AW-1:0]  ent_addr;
    logic [ENTRY_W-1:0] ent_q;
    logic               desc_rd_en;
    logic               desc_wr_en;
    logic [HEAD_W-1:0]  desc_wr_head;
    logic [CNT_W-1:0]   desc_wr_cnt;
    logic               ent_rd_en;
    logic               ent_wr_en;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign bad_bank = ({1'b0, s_tdata[2:0]} >= 4'(BANK_COUNT));
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // fifo number and entry address of the current bank and level
    assign fifo_idx = FIFO_W'(({2'b00, bank_reg} * 5'd3) + {3'b000, lvl_reg});
    assign {desc_head, desc_cnt} = desc_q;

    // circular slot: head plus offset, wrapped once at the fifo depth
    assign slot_head = (state_reg == S_DESC_CHK) ? desc_head : head_reg;
    assign slot_off  = (state_reg == S_DESC_CHK) ? desc_cnt : pos_reg;
    assign slot_sum  = SUM_W'(slot_head) + SUM_W'(slot_off);
    assign slot      = (slot_sum >= SUM_W'(FIFO_DEPTH))
                       ? HEAD_W'(slot_sum - SUM_W'(FIFO_DEPTH)) : HEAD_W'(slot_sum);
    assign ent_addr  = ENT_AW'(fifo_idx) * ENT_AW'(FIFO_DEPTH) + ENT_AW'(slot);

    assign head_inc = (head_reg == HEAD_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign pos_inc  = pos_reg + CNT_W'(1);

    // descriptor and entry memories
    bspq_desc_store #(
        .WIDTH (DESC_W),
        .DEPTH (NFIFO)
    ) u_desc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (desc_wr_en),
        .wr_addr (fifo_idx),
        .wr_data ({desc_wr_head, desc_wr_cnt}),
        .rd_en   (desc_rd_en),
        .rd_addr (fifo_idx),
        .rd_data (desc_q)
    );

    bspq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENT_DEPTH)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_addr),
        .wr_data ({id_reg, age_reg, pri_reg}),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_addr),
        .rd_data (ent_q)
    );

    // sequencer: read descriptor, read entries for dequeue and find, write back for enqueue and dequeue
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        bank_next    = bank_reg;
        lvl_next     = lvl_reg;
        id_next      = id_reg;
        age_next     = age_reg;
        pri_next     = pri_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        res_next     = res_reg;
        find_adv     = 1'b0;
        desc_rd_en   = 1'b0;
        desc_wr_en   = 1'b0;
        desc_wr_head = desc_head;
        desc_wr_cnt  = desc_cnt + CNT_W'(1);
        ent_rd_en    = 1'b0;
        ent_wr_en    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    mode_next = s_tuser;
                    bank_next = s_tdata[2:0];
                    id_next   = s_tdata[18:3];
                    age_next  = s_tdata[26:19];
                    pri_next  = s_tdata[28:27];
                    res_next  = '0;
                    case (s_tuser)
                        MODE_ENQ: begin
                            lvl_next = level_of(s_tdata[28:27]);
                            if (bad_bank) begin
                                res_next.status = STAT_BAD_BANK;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_DESC_RD;
                            end
                        end
                        MODE_DEQ: begin
                            lvl_next = LVL_CRIT;
                            if (bad_bank) begin
                                res_next.status = STAT_BAD_BANK;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_DESC_RD;
                            end
                        end
                        MODE_FIND: begin
                            bank_next  = 3'd0;
                            lvl_next   = LVL_CRIT;
                            state_next = S_DESC_RD;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DESC_RD: begin
                desc_rd_en = 1'b1;
                state_next = S_DESC_CHK;
            end
            S_DESC_CHK: begin
                head_next = desc_head;
                cnt_next  = desc_cnt;
                pos_next  = '0;
                case (mode_reg)
                    MODE_ENQ: begin
                        if (desc_cnt >= CNT_W'(FIFO_DEPTH)) begin
                            res_next.status = STAT_FULL;
                        end else begin
                            ent_wr_en  = 1'b1;
                            desc_wr_en = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    MODE_DEQ: begin
                        if (desc_cnt != '0) begin
                            state_next = S_ENT_RD;
                        end else if (lvl_reg == LVL_NORMAL) begin
                            res_next.status = STAT_EMPTY;
                            state_next      = S_DONE;
                        end else begin
                            lvl_next   = lvl_reg + 2'd1;
                            state_next = S_DESC_RD;
                        end
                    end
                    default: begin
                        if (desc_cnt != '0) begin
                            state_next = S_ENT_RD;
                        end else begin
                            find_adv = 1'b1;
                        end
                    end
                endcase
            end
            S_ENT_RD: begin
                ent_rd_en  = 1'b1;
                state_next = S_ENT_CHK;
            end
            S_ENT_CHK: begin
                if (mode_reg == MODE_DEQ) begin
                    desc_wr_en            = 1'b1;
                    desc_wr_head          = head_inc;
                    desc_wr_cnt           = cnt_reg - CNT_W'(1);
                    res_next.status       = STAT_OK;
                    res_next.out_id       = ent_q[ENTRY_W-1 -: ID_W];
                    res_next.out_age      = ent_q[PRI_W +: AGE_W];
                    res_next.out_priority = ent_q[PRI_W-1:0];
                    state_next            = S_DONE;
                end else if (ent_q[ENTRY_W-1 -: ID_W] == id_reg) begin
                    res_next.status         = STAT_OK;
                    res_next.found_bank     = bank_reg;
                    res_next.found_level    = lvl_reg;
                    res_next.found_position = 5'(pos_inc);
                    state_next              = S_DONE;
                end else if (pos_inc == cnt_reg) begin
                    find_adv = 1'b1;
                end else begin
                    pos_next   = pos_inc;
                    state_next = S_ENT_RD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // find moves on to the next level, then the next bank
        if (find_adv) begin
            if (lvl_reg == LVL_NORMAL) begin
                if (bank_reg == 3'(BANK_COUNT - 1)) begin
                    res_next.status = STAT_NOT_FOUND;
                    state_next      = S_DONE;
                end else begin
                    bank_next  = bank_reg + 3'd1;
                    lvl_next   = LVL_CRIT;
                    state_next = S_DESC_RD;
                end
            end else begin
                lvl_next   = lvl_reg + 2'd1;
                state_next = S_DESC_RD;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers of the item in flight
    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        bank_reg <= bank_next;
        lvl_reg  <= lvl_next;
        id_reg   <= id_next;
        age_reg  <= age_next;
        pri_reg  <= pri_next;
        head_reg <= head_next;
        cnt_reg  <= cnt_next;
        pos_reg  <= pos_next;
        res_reg  <= res_next;
    end

    // output register: holds a result while the sequencer takes the next item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_res_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {4'b0000, m_res_reg.found_position, m_res_reg.found_level,
                       m_res_reg.found_bank, m_res_reg.out_priority,
                       m_res_reg.out_age, m_res_reg.out_id};

    // checks
    `ASSERT_NEXT(a_done_loads, aclk, aresetn, out_load, m_tvalid_reg && (state_reg == S_IDLE), "result not presented after completion")
    `ASSERT_IMPL(a_scan_in_range, aclk, aresetn, state_reg == S_ENT_RD, pos_reg < cnt_reg, "entry read beyond fifo fill")
    `ASSERT_IMPL(a_fill_bound, aclk, aresetn, desc_wr_en, desc_wr_cnt <= CNT_W'(FIFO_DEPTH), "fill count written above depth")

endmodule

/* tb/banked_strict_priority_queues_tb.sv */
// testbench for banked_strict_priority_queues: directed and random enqueue, dequeue and find
// traffic with random idling on both stream channels, checked by a scoreboard model
// depends on bspq_pkg and the banked_strict_priority_queues rtl
`timescale 1ns / 1ps

module banked_strict_priority_queues_tb
    import bspq_pkg::*;
();

    localparam int BANKS  = 5;
    localparam int DEPTH  = 16;
    localparam int NUM_Q  = BANKS * LEVELS;
    localparam int IDLE_PCT = 32;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // bank[2:0], rec_id[18:3], rec_age[26:19], rec_priority[28:27]
    logic [1:0]  s_tuser  = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // out_id[15:0], out_age[23:16], out_priority[25:24],
                                  // found_bank[28:26], found_level[30:29], found_position[35:31]
    logic [2:0]  m_tuser;         // status[2:0]

    // no idling on either side while set
    bit calm = 1'b0;

    // model of the queues plus the list of answers still owed by the block
    class bspq_scoreboard;
        typedef struct {
            logic [ID_W-1:0]  id;
            logic [AGE_W-1:0] age;
            logic [PRI_W-1:0] pri;
        } stored_rec_t;

        stored_rec_t slots [NUM_Q][DEPTH];
        int unsigned head [NUM_Q];
        int unsigned fill [NUM_Q];
        res_t        awaited_answers [$];
        int          errors;

        // apply one request to the model and queue the answer it should give
        function void note_request(logic [1:0] mode, logic [2:0] bank, logic [ID_W-1:0] id,
                                   logic [AGE_W-1:0] age, logic [PRI_W-1:0] pri);
            res_t        ans;
            int          q;
            int          lvl;
            bit          hit;
            stored_rec_t rec;
            ans = '0;
            case (mode)
                MODE_ENQ: begin
                    if (bank >= BANKS) begin
                        ans.status = STAT_BAD_BANK;
                    end else begin
                        lvl = (pri == PRI_CRIT) ? LVL_CRIT :
                              (pri == PRI_URGENT) ? LVL_URGENT : LVL_NORMAL;
                        q = bank * LEVELS + lvl;
                        if (fill[q] >= DEPTH) begin
                            ans.status = STAT_FULL;
                        end else begin
                            slots[q][(head[q] + fill[q]) % DEPTH] = '{id, age, pri};
                            fill[q]++;
                            ans.status = STAT_OK;
                        end
                    end
                end
                MODE_DEQ: begin
                    if (bank >= BANKS) begin
                        ans.status = STAT_BAD_BANK;
                    end else begin
                        ans.status = STAT_EMPTY;
                        hit = 1'b0;
                        // strict priority: first non-empty level wins
                        for (lvl = 0; lvl < LEVELS && !hit; lvl++) begin
                            q = bank * LEVELS + lvl;
                            if (fill[q] != 0) begin
                                rec = slots[q][head[q]];
                                head[q] = (head[q] + 1) % DEPTH;
                                fill[q]--;
                                hit = 1'b1;
                                ans.status       = STAT_OK;
                                ans.out_id       = rec.id;
                                ans.out_age      = rec.age;
                                ans.out_priority = rec.pri;
                            end
                        end
                    end
                end
                MODE_FIND: begin
                    ans.status = STAT_NOT_FOUND;
                    hit = 1'b0;
                    // banks, then levels, then positions from the head
                    for (int b = 0; b < BANKS && !hit; b++) begin
                        for (lvl = 0; lvl < LEVELS && !hit; lvl++) begin
                            q = b * LEVELS + lvl;
                            for (int j = 0; j < fill[q] && !hit; j++) begin
                                if (slots[q][(head[q] + j) % DEPTH].id == id) begin
                                    hit = 1'b1;
                                    ans.status         = STAT_OK;
                                    ans.found_bank     = 3'(b);
                                    ans.found_level    = 2'(lvl);
                                    ans.found_position = 5'(j + 1);
                                end
                            end
                        end
                    end
                end
                default: begin
                    ans.status = STAT_OK;
                end
            endcase
            awaited_answers.push_back(ans);
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one result transfer against the oldest owed answer
        function void check_answer(logic [2:0] user, logic [39:0] data);
            res_t ans;
            if (awaited_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0h data %0h",
                         $time, user, data);
                errors++;
                return;
            end
            ans = awaited_answers.pop_front();
            check_field("status", ans.status, user);
            check_field("out_id", ans.out_id, data[15:0]);
            check_field("out_age", ans.out_age, data[23:16]);
            check_field("out_priority", ans.out_priority, data[25:24]);
            check_field("found_bank", ans.found_bank, data[28:26]);
            check_field("found_level", ans.found_level, data[30:29]);
            check_field("found_position", ans.found_position, data[35:31]);
            check_field("tdata fill", 0, data[39:36]);
        endfunction

        function int pending();
            return awaited_answers.size();
        endfunction
    endclass

    bspq_scoreboard board = new();

    banked_strict_priority_queues #(
        .BANK_COUNT(BANKS),
        .FIFO_DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side: check each transfer, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                board.check_answer(m_tuser, m_tdata);
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic send_item(input logic [1:0] mode, input logic [2:0] bank,
                             input logic [ID_W-1:0] id, input logic [AGE_W-1:0] age,
                             input logic [PRI_W-1:0] pri);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, pri, age, id, bank};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(mode, bank, id, age, pri);
    endtask

    // hold the input quiet until every owed answer has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // random request; small id pool makes duplicates and find hits common
    task automatic random_item(input int enq_pct, input int deq_pct, input int hot_top);
        int               roll;
        logic [1:0]       mode;
        logic [2:0]       bank;
        logic [ID_W-1:0]  id;
        roll = $urandom_range(99);
        if (roll < 3) begin
            mode = MODE_NOP;
        end else if (roll < 3 + enq_pct) begin
            mode = MODE_ENQ;
        end else if (roll < 3 + enq_pct + deq_pct) begin
            mode = MODE_DEQ;
        end else begin
            mode = MODE_FIND;
        end
        if (mode != MODE_FIND && $urandom_range(99) < 85) begin
            bank = 3'($urandom_range(0, hot_top));
        end else begin
            bank = 3'($urandom_range(0, 7));
        end
        id = ($urandom_range(1) == 1) ? ID_W'($urandom_range(0, 23)) : ID_W'($urandom());
        send_item(mode, bank, id, AGE_W'($urandom()), PRI_W'($urandom_range(0, 3)));
    endtask

    // stimulus
    initial begin
        int enq_mix [6] = '{75, 40, 15, 70, 45, 20};
        int deq_mix [6] = '{10, 30, 65, 10, 35, 65};
        int hot_mix [6] = '{1, 4, 4, 2, 4, 4};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, every level, field extremes, bad banks, unused mode
        send_item(MODE_DEQ, 3'd0, 16'h0000, 8'h00, 2'd0);
        send_item(MODE_FIND, 3'd7, 16'h0000, 8'h00, 2'd0);
        send_item(MODE_ENQ, 3'd0, 16'h0000, 8'h00, 2'd0);
        send_item(MODE_ENQ, 3'd0, 16'hFFFF, 8'hFF, 2'd3);
        send_item(MODE_ENQ, 3'd0, 16'h1234, 8'h5A, PRI_URGENT);
        send_item(MODE_ENQ, 3'd0, 16'hABCD, 8'hA5, PRI_CRIT);
        send_item(MODE_ENQ, 3'(BANKS - 1), 16'hFFFF, 8'h80, PRI_CRIT);
        send_item(MODE_ENQ, 3'(BANKS), 16'h5555, 8'h55, PRI_CRIT);
        send_item(MODE_ENQ, 3'd7, 16'hAAAA, 8'hAA, 2'd3);
        send_item(MODE_DEQ, 3'd7, 16'hFFFF, 8'hFF, 2'd3);
        send_item(MODE_NOP, 3'd5, 16'hFFFF, 8'hFF, 2'd3);
        send_item(MODE_FIND, 3'd0, 16'hFFFF, 8'h00, 2'd0);
        send_item(MODE_FIND, 3'd3, 16'hABCD, 8'h00, 2'd0);
        send_item(MODE_FIND, 3'd0, 16'h7777, 8'h00, 2'd0);
        send_item(MODE_DEQ, 3'd0, 16'h0000, 8'h00, 2'd0);
        send_item(MODE_DEQ, 3'd0, 16'h0000, 8'h00, 2'd0);
        send_item(MODE_DEQ, 3'd0, 16'h0000, 8'h00, 2'd0);
        send_item(MODE_DEQ, 3'd0, 16'h0000, 8'h00, 2'd0);
        send_item(MODE_DEQ, 3'd0, 16'h0000, 8'h00, 2'd0);
        send_item(MODE_FIND, 3'd0, 16'hFFFF, 8'h00, 2'd0);
        send_item(MODE_DEQ, 3'(BANKS - 1), 16'h0000, 8'h00, 2'd0);
        send_item(MODE_DEQ, 3'(BANKS - 1), 16'h0000, 8'h00, 2'd0);

        // random phases: fill, mixed, drain, run twice, with a bank spread set per phase
        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 3) begin
                drain();
            end
            calm = (seg == 4);
            for (int n = 0; n < 125; n++) begin
                random_item(enq_mix[seg], deq_mix[seg], hot_mix[seg]);
            end
        end
        calm = 1'b0;

        // wrap up once every answer is in
        drain();
        repeat (20) @(posedge aclk);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #25_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bspq_pkg.sv
hw/rtl/bspq_ram.sv
hw/rtl/bspq_desc_store.sv
hw/rtl/banked_strict_priority_queues.sv
tb/banked_strict_priority_queues_tb.sv
